// ===== rtl/core/srm_pkg.sv =====
`default_nettype none
// ============================================================================
// srm_pkg: shared types and constants of the sparse-table range-max engine
// Request and response payloads, the front-to-back command word and the
// back-end sequencer states.
// ============================================================================
package srm_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int LEVELS_DEF       = 11;
  localparam int VALUE_WIDTH      = 32;
  localparam int IDX_W            = 10;  // width of left / right request fields
  localparam int LVL_W            = 5;   // holds any level number up to 32 levels
  localparam int QUEUE_DEPTH      = 2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
    logic [IDX_W-1:0]              left;
    logic [IDX_W-1:0]              right;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] max_value;
    logic                          range_error;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_ERROR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                       op;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
    logic [IDX_W-1:0]              idx_a;
    logic [IDX_W-1:0]              idx_b;
    logic [LVL_W-1:0]              level;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RDA,
    BK_RDB,
    BK_WR,
    BK_QB,
    BK_QR
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/srm_ram.sv =====
`default_nettype none
// ============================================================================
// srm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module srm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/srm_fifo.sv =====
`default_nettype none
// ============================================================================
// srm_fifo: small register queue
// Push ignored while full, pop ignored while empty; head shown combinationally.
// ============================================================================
module srm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNW-1:0]   count;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full    = (count == CNW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + CNW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/srm_front.sv =====
`default_nettype none
// ============================================================================
// srm_front: request classifier
// Tracks load count and build status, sorts each request into load, query or
// error, and precomputes the query level and both table indexes.
// ============================================================================
module srm_front import srm_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int LEVELS       = LEVELS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire req_t req,
  input  wire logic cmd_full,
  output logic      cmd_push,
  output cmd_t      cmd
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int RW = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0]    count;
  logic             built;
  logic [CW-1:0]    base;
  logic [CW-1:0]    count_next;
  logic             accept;
  logic             err;
  logic [IDX_W:0]   len;
  logic [IDX_W:0]   pow;
  logic [LVL_W-1:0] k;

  assign accept   = push && !cmd_full;
  assign cmd_push = accept;

  always_comb begin
    base       = built ? '0 : count;
    count_next = (base == CW'(MAX_ELEMENTS)) ? base : base + CW'(1);

    err = !built || (req.left > req.right) || (RW'(req.right) >= RW'(count));
    len = {1'b0, req.right} - {1'b0, req.left} + (IDX_W + 1)'(1);

    // floor(log2(len)), clamped to the top level
    k = '0;
    for (int b = 1; b <= IDX_W; b++) begin
      if (len[b]) begin
        k = LVL_W'(b);
      end
    end
    if (k > LVL_W'(LEVELS - 1)) begin
      k = LVL_W'(LEVELS - 1);
    end
    pow = (IDX_W + 1)'(1) << k;

    cmd.value = req.value;
    cmd.last  = req.last;
    cmd.idx_a = req.left;
    cmd.idx_b = IDX_W'({1'b0, req.right} + (IDX_W + 1)'(1) - pow);
    cmd.level = k;
    if (req.req_type == REQ_LOAD) begin
      cmd.op = OP_LOAD;
    end else if (err) begin
      cmd.op = OP_ERROR;
    end else begin
      cmd.op = OP_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      built <= 1'b0;
    end else if (accept && req.req_type == REQ_LOAD) begin
      count <= count_next;
      built <= req.last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/srm_back.sv =====
`default_nettype none
// ============================================================================
// srm_back: table sequencer
// Executes loads, builds the upper levels after the last load, and answers
// queries with two reads through the one read port of the level table.
// ============================================================================
module srm_back import srm_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int LEVELS       = LEVELS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  input  wire logic rsp_full,
  output logic      rsp_push,
  output rsp_t      rsp
);

  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int IW    = $clog2(MAX_ELEMENTS);
  localparam int LW    = $clog2(LEVELS);
  localparam int DEPTH = LEVELS * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ((CW > LEVELS) ? CW : LEVELS) + 1;

  back_state_t                   state, state_next;
  logic [LW-1:0]                 lvl, lvl_next;
  logic [IW-1:0]                 j, j_next;
  logic [CW-1:0]                 count, count_next;
  logic                          built, built_next;
  logic [IW-1:0]                 q_idx_b, q_idx_b_next;
  logic [LW-1:0]                 q_level, q_level_next;
  logic signed [VALUE_WIDTH-1:0] a_hold, a_hold_next;

  logic [CW-1:0]          base;
  logic [CW-1:0]          cnt_load;
  logic [XW-1:0]          span_x;
  logic [XW-1:0]          half_x;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [VALUE_WIDTH-1:0] pair_max;

  function automatic logic [AW-1:0] taddr(input logic [LW-1:0] l, input logic [IW-1:0] i);
    return AW'(l) * AW'(MAX_ELEMENTS) + AW'(i);
  endfunction

  srm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pair_max = ($signed(a_hold) > $signed(rdata)) ? a_hold : rdata;

  always_comb begin
    state_next   = state;
    lvl_next     = lvl;
    j_next       = j;
    count_next   = count;
    built_next   = built;
    q_idx_b_next = q_idx_b;
    q_level_next = q_level;
    a_hold_next  = a_hold;

    cmd_pop         = 1'b0;
    rsp_push        = 1'b0;
    rsp.max_value   = '0;
    rsp.range_error = 1'b1;
    we              = 1'b0;
    waddr           = taddr(lvl, j);
    wdata           = pair_max;
    raddr           = taddr(q_level, q_idx_b);

    base     = built ? '0 : count;
    cnt_load = (base == CW'(MAX_ELEMENTS)) ? base : base + CW'(1);
    span_x   = XW'(1) << lvl;
    half_x   = XW'(1) << (lvl - LW'(1));

    case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.op)
            OP_LOAD: begin
              cmd_pop = 1'b1;
              // drop the value once the table is full
              if (base != CW'(MAX_ELEMENTS)) begin
                we    = 1'b1;
                waddr = taddr('0, IW'(base));
                wdata = cmd.value;
              end
              count_next = cnt_load;
              built_next = cmd.last;
              if (cmd.last && cnt_load >= CW'(2)) begin
                lvl_next   = LW'(1);
                j_next     = '0;
                state_next = BK_RDA;
              end
            end
            OP_QUERY: begin
              if (!rsp_full) begin
                cmd_pop      = 1'b1;
                raddr        = taddr(LW'(cmd.level), IW'(cmd.idx_a));
                q_idx_b_next = IW'(cmd.idx_b);
                q_level_next = LW'(cmd.level);
                state_next   = BK_QB;
              end
            end
            OP_ERROR: begin
              if (!rsp_full) begin
                cmd_pop  = 1'b1;
                rsp_push = 1'b1;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      BK_RDA: begin
        raddr      = taddr(lvl - LW'(1), j);
        state_next = BK_RDB;
      end
      BK_RDB: begin
        raddr       = taddr(lvl - LW'(1), IW'(XW'(j) + half_x));
        a_hold_next = rdata;
        state_next  = BK_WR;
      end
      BK_WR: begin
        we = 1'b1;
        if (XW'(j) + XW'(1) + span_x <= XW'(count)) begin
          j_next     = j + IW'(1);
          state_next = BK_RDA;
        end else if (lvl != LW'(LEVELS - 1) && (span_x << 1) <= XW'(count)) begin
          lvl_next   = lvl + LW'(1);
          j_next     = '0;
          state_next = BK_RDA;
        end else begin
          state_next = BK_IDLE;
        end
      end
      BK_QB: begin
        a_hold_next = rdata;
        state_next  = BK_QR;
      end
      BK_QR: begin
        rsp_push        = 1'b1;
        rsp.max_value   = pair_max;
        rsp.range_error = 1'b0;
        state_next      = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      count <= '0;
      built <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      built <= built_next;
    end
  end

  always_ff @(posedge clk) begin
    lvl     <= lvl_next;
    j       <= j_next;
    q_idx_b <= q_idx_b_next;
    q_level <= q_level_next;
    a_hold  <= a_hold_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sparse_table_range_max.sv =====
`default_nettype none
// ============================================================================
// sparse_table_range_max: sparse-table range-maximum engine
// Loads fill level 0, the last load triggers a build of the upper levels, and
// queries return the maximum of two overlapping level entries.
// ============================================================================
//
//   channel   handshake            payload  direction
//   --------  -------------------  -------  ---------
//   request   push / full          req      in
//   result    pop / empty          rsp      out
//
// Sequencing: a load is done in the sequencer's idle state; a valid query
// runs idle, QB, QR (two reads through the one read port of the level table
// plus the compare); a rejected query is answered in idle. The build after
// the last load runs RDA, RDB and WR per entry of every upper level.
// Reset: rst is synchronous; it clears both queues, counters and the
// sequencer. The table itself is not cleared and needs no clearing pass.
// Stalls: full rises when the 2-entry command queue fills, e.g. during a
// build; the sequencer holds queries while the 2-entry result queue is full.
//
module sparse_table_range_max import srm_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int LEVELS       = LEVELS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire req_t req,
  output logic      empty,
  input  wire logic pop,
  output rsp_t      rsp
);

  // front classifies into the command queue
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_full;
  logic cmd_empty;

  // back pushes answers into the result queue
  rsp_t rsp_in;
  logic rsp_push;
  logic rsp_full;

  assign full = cmd_full;

  srm_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .req      (req),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  srm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  srm_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .rsp_full  (rsp_full),
    .rsp_push  (rsp_push),
    .rsp       (rsp_in)
  );

  // result queue: a finished answer waits here while new requests transfer
  srm_fifo #(
    .WIDTH ($bits(rsp_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_rsp_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rsp_push),
    .wdata (rsp_in),
    .pop   (pop),
    .rdata (rsp),
    .full  (rsp_full),
    .empty (empty)
  );

`ifndef ASSERT_OFF
  // an answer is only produced when the result queue has room for it
  a_rsp_room: assert property (@(posedge clk) disable iff (rst)
    rsp_push |-> !rsp_full)
    else $error("result produced while result queue full");

  // the sequencer only takes a command that is really there
  a_cmd_avail: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from empty queue");

  // both queues come out of reset drained
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not drained after reset");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the sparse-table range-max engine
// Drives load and query transfers through the request queue, predicts every
// query result from a flat copy of the loaded elements, and compares each
// popped result field by field. Both sides idle and stall at random.
// ============================================================================
module tb_top;
  import srm_pkg::*;

  localparam int MAX_ELEMENTS   = MAX_ELEMENTS_DEF;
  localparam int WATCHDOG_LIMIT = 100000;  // covers a full 1024-entry build
  localparam int MAX_REPORTS    = 40;      // keep the log short on a bad day
  localparam int RANDOM_ITEMS   = 50;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic push  = 1'b0;
  logic pop   = 1'b0;
  req_t req   = '0;
  logic full;
  logic empty;
  rsp_t rsp;

  always #5 clk = ~clk;

  sparse_table_range_max dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .req   (req),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

  // --------------------------------------------------------------------------
  // Range-max predictor. Keep level 0 as loaded; the answer to a query is the
  // plain maximum over [left, right], which is what the two overlapping
  // sparse-table windows must produce.
  // --------------------------------------------------------------------------
  logic signed [VALUE_WIDTH-1:0] elem_vals [MAX_ELEMENTS];
  int unsigned                   elem_count   = 0;
  bit                            levels_ready = 1'b0;

  rsp_t        pending_maxima [$];  // expected results, oldest first
  int unsigned sent_count = 0;
  int unsigned err_count  = 0;
  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;

  task automatic absorb_load(input req_t item);
    // A load after a finished build starts a fresh table.
    if (levels_ready) begin
      levels_ready = 1'b0;
      elem_count   = 0;
    end
    // Drop values that no longer fit; the count saturates.
    if (elem_count < MAX_ELEMENTS) begin
      elem_vals[elem_count] = item.value;
      elem_count++;
    end
    if (item.last) levels_ready = 1'b1;
  endtask

  function automatic rsp_t range_max_of(input req_t item);
    rsp_t res;
    res = '0;
    if (!levels_ready || item.left > item.right || item.right >= elem_count) begin
      res.range_error = 1'b1;
    end else begin
      res.max_value = elem_vals[item.left];
      for (int i = item.left + 1; i <= item.right; i++) begin
        if (elem_vals[i] > res.max_value) res.max_value = elem_vals[i];
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request builders. Fill the fields the block must ignore with noise.
  // --------------------------------------------------------------------------
  function automatic logic signed [VALUE_WIDTH-1:0] rand_value();
    case ($urandom_range(0, 19))
      0: return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      1: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t load_req(input logic signed [VALUE_WIDTH-1:0] v,
                                    input logic is_last);
    req_t r;
    r.req_type = REQ_LOAD;
    r.value    = v;
    r.last     = is_last;
    r.left     = IDX_W'($urandom);
    r.right    = IDX_W'($urandom);
    return r;
  endfunction

  function automatic req_t query_req(input logic [IDX_W-1:0] lo,
                                     input logic [IDX_W-1:0] hi);
    req_t r;
    r.req_type = REQ_QUERY;
    r.value    = $urandom;
    r.last     = 1'($urandom);
    r.left     = lo;
    r.right    = hi;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Idle for a few cycles now and then, then hold push until the
  // transfer happens. Push is left high on return so back-to-back items need
  // no second assignment in the same step; every wait path lowers it first.
  // --------------------------------------------------------------------------
  task automatic send_req(input req_t item);
    if (src_idle_en && $urandom_range(0, 99) < 10) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    req  <= item;
    do @(posedge clk); while (full);
    if (item.req_type == REQ_LOAD) absorb_load(item);
    else pending_maxima.push_back(range_max_of(item));
    sent_count++;
  endtask

  // Hold the sender until every outstanding result has been popped; always
  // step the clock before checking so push is lowered in a step of its own.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending_maxima.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random pop stalls, and the check of every transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= !(sink_idle_en && $urandom_range(0, 99) < 10);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < MAX_REPORTS)
      $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  rsp_t want_rsp;

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_maxima.size() == 0) begin
        report_mismatch("unexpected result", 64'(rsp), '0);
      end else begin
        want_rsp = pending_maxima.pop_front();
        if (rsp.range_error !== want_rsp.range_error)
          report_mismatch("range_error", 64'(rsp.range_error),
                          64'(want_rsp.range_error));
        if (rsp.max_value !== want_rsp.max_value)
          report_mismatch("max_value", 64'(rsp.max_value), 64'(want_rsp.max_value));
      end
    end
  end

  // Watchdog: end the run when no transfer has happened for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Nothing has been built yet: every query must come back as an error.
  task automatic test_query_before_build();
    send_req(query_req(0, 0));
    send_req(query_req(1023, 1023));
    send_req(query_req(5, 2));
    drain_results();
  endtask

  // Load the value extremes, probe a query while the load is still open,
  // then cover single elements, every window level up to the full set, and
  // each error case.
  task automatic test_extreme_values();
    send_req(load_req({1'b1, {(VALUE_WIDTH-1){1'b0}}}, 1'b0));
    send_req(load_req({1'b0, {(VALUE_WIDTH-1){1'b1}}}, 1'b0));
    send_req(load_req('1, 1'b0));
    send_req(query_req(0, 0));              // load still open: error
    send_req(load_req('0, 1'b0));
    send_req(load_req(1, 1'b0));
    send_req(load_req(32'sh5555_5555, 1'b1));
    send_req(query_req(0, 5));
    send_req(query_req(0, 0));
    send_req(query_req(2, 3));
    send_req(query_req(3, 5));
    send_req(query_req(1, 4));
    send_req(query_req(5, 5));
    send_req(query_req(4, 3));              // left past right
    send_req(query_req(0, 6));              // right at the loaded count
    send_req(query_req(1023, 1023));
    send_req(query_req(0, 1023));
    drain_results();
  endtask

  // A load after a build restarts the table at element 0.
  task automatic test_reload_after_build();
    send_req(load_req(-7, 1'b0));
    send_req(query_req(0, 0));
    send_req(load_req(32'sh1234, 1'b1));
    send_req(query_req(0, 1));
    send_req(query_req(1, 1));
    send_req(query_req(0, 0));
    send_req(query_req(0, 2));
    drain_results();
  endtask

  // Fill every slot, push two more that must be dropped, the second one
  // closing the load, then query the widest windows. Run the whole test as
  // one long stretch with no idling on either side.
  task automatic test_full_table();
    int unsigned lo;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < MAX_ELEMENTS + 2; i++)
      send_req(load_req(rand_value(), i == MAX_ELEMENTS + 1));
    send_req(query_req(0, 1023));
    send_req(query_req(1023, 1023));
    send_req(query_req(512, 1023));
    send_req(query_req(1, 1023));
    for (int i = 0; i < 30; i++) begin
      lo = $urandom_range(0, MAX_ELEMENTS - 1);
      send_req(query_req(IDX_W'(lo), IDX_W'($urandom_range(lo, MAX_ELEMENTS - 1))));
    end
    for (int i = 0; i < 6; i++) send_req(query_req(IDX_W'($urandom), IDX_W'($urandom)));
    drain_results();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // Random load sets, mostly small, each followed by a burst of queries.
  // Most queries are well formed; the rest are reversed or pure noise. A few
  // sets leave the load open or get a stray query in the middle.
  task automatic test_random_sets();
    int unsigned goal;
    int unsigned set_len;
    int unsigned n_queries;
    int unsigned pick;
    int unsigned lo;
    bit          close_set;
    goal = sent_count + RANDOM_ITEMS;
    while (sent_count < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) set_len = $urandom_range(1, 32);
      else if (pick < 97) set_len = $urandom_range(33, 200);
      else set_len = $urandom_range(201, 600);
      // keep the run near its item budget
      if (set_len > goal - sent_count) set_len = goal - sent_count;
      close_set = $urandom_range(0, 99) >= 5;
      for (int i = 0; i < set_len; i++) begin
        if ($urandom_range(0, 99) < 3)
          send_req(query_req(IDX_W'($urandom), IDX_W'($urandom)));
        send_req(load_req(rand_value(), close_set && i == set_len - 1));
      end

      n_queries = $urandom_range(4, 24);
      for (int i = 0; i < n_queries; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80 && elem_count > 0) begin
          lo = $urandom_range(0, elem_count - 1);
          send_req(query_req(IDX_W'(lo), IDX_W'($urandom_range(lo, elem_count - 1))));
        end else if (pick < 90) begin
          lo = $urandom_range(1, 1023);
          send_req(query_req(IDX_W'(lo), IDX_W'($urandom_range(0, lo - 1))));
        end else begin
          send_req(query_req(IDX_W'($urandom), IDX_W'($urandom)));
        end
      end

      if ($urandom_range(0, 7) == 0) drain_results();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_query_before_build();
    test_extreme_values();
    test_reload_after_build();
    test_full_table();
    test_random_sets();

    // Wait out the last results, then give stray ones a chance to show up.
    drain_results();
    repeat (50) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
